/* rtl/blsa_pkg.sv */
`timescale 1ns / 1ps
package blsa_pkg;

	localparam int SLOTS_DEF    = 64;
	localparam int BUFFERS_DEF  = 256;
	localparam int PROGRAMS_DEF = 16;
	localparam int UNITS_W      = 7;
	localparam logic [UNITS_W-1:0] UNITS_RESET = 7'd64;

	localparam logic [2:0] KIND_BIND    = 3'd0;
	localparam logic [2:0] KIND_ADD     = 3'd1;
	localparam logic [2:0] KIND_REMOVE  = 3'd2;
	localparam logic [2:0] KIND_RELEASE = 3'd3;
	localparam logic [2:0] KIND_UNBIND  = 3'd4;

	localparam logic [2:0] STAT_OK           = 3'd0;
	localparam logic [2:0] STAT_NO_SLOT      = 3'd1;
	localparam logic [2:0] STAT_USER_PRESENT = 3'd2;
	localparam logic [2:0] STAT_USER_ABSENT  = 3'd3;
	localparam logic [2:0] STAT_BAD_PROGRAM  = 3'd4;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] buffer;
		logic [3:0] program_req;
	} in_t;

	typedef struct packed {
		logic [5:0] unit;
		logic [2:0] status;
	} out_t;

	typedef struct packed {
		logic        valid;
		logic [7:0]  buffer;
		logic [31:0] stamp;
	} slot_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_TAIL,
		S_APPLY,
		S_UREAD,
		S_UWRITE
	} state_t;

endpackage

/* rtl/blsa_ram.sv */
`timescale 1ns / 1ps
module blsa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* rtl/blsa_cell.sv */
`timescale 1ns / 1ps
module blsa_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift,
	input  logic           clr,
	input  logic           load,
	input  blsa_pkg::slot_t d,
	input  blsa_pkg::slot_t load_d,
	output blsa_pkg::slot_t q
);
	import blsa_pkg::*;

	slot_t slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (clr) begin
			slot_q <= '0;
		end else if (load) begin
			slot_q <= load_d;
		end else if (shift) begin
			slot_q <= d;
		end
	end

	assign q = slot_q;
endmodule

/* rtl/binding_slot_lru_allocator_core.sv */
`timescale 1ns / 1ps
// Binding slot allocator. Slots live in a ring of cells that rotates once per bind or
// release, so those requests pass through the scan and tail states (bind adds the apply
// state to commit); add user and remove user pass through a read and a write of the
// user bitmap memory; unbind all, bad requests and unknown kinds are answered from idle.
// The result appears on result for one cycle with done high, in the cycle after the
// work ends, and cannot be stalled. After reset it stays busy while zeroing user memory.
module binding_slot_lru_allocator_core #(
	parameter int SLOTS    = blsa_pkg::SLOTS_DEF,
	parameter int BUFFERS  = blsa_pkg::BUFFERS_DEF,
	parameter int PROGRAMS = blsa_pkg::PROGRAMS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  blsa_pkg::in_t  request,
	output logic           done,
	output blsa_pkg::out_t result,
	input  logic           cfg_we,
	input  logic [6:0]     cfg_wdata
);
	import blsa_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int AW = $clog2(BUFFERS);
	localparam int PW = $clog2(PROGRAMS);

	state_t state_q, state_d;
	in_t    req_q;
	logic [IW-1:0] idx_q, hit_idx_q, free_idx_q, best_idx_q, ev_idx_s1, sel_idx;
	logic [AW-1:0] clr_q, ram_wa, ram_ra;
	logic [31:0] clock_q, oldest_q, ev_stamp_s1;
	logic [UNITS_W-1:0] units_q;
	logic hit_q, free_q, best_q, ev_s1, ev_bufok_s1;
	logic done_q;
	out_t result_q, emit_r;
	logic emit, ram_we, clr_all, load_en, shift;
	logic [PROGRAMS-1:0] ram_wd, ram_rd, mask;
	slot_t cell_q [SLOTS];
	slot_t head, tail_d, load_d;
	logic head_match, rel_free, used, prog_ok, bad_bind, req_buf_ok;
	logic [PW-1:0] prog_idx;

	assign head       = cell_q[0];
	assign head_match = head.valid && (head.buffer == req_q.buffer);
	assign rel_free   = (req_q.kind == KIND_RELEASE) && head_match;
	assign tail_d     = rel_free ? slot_t'{valid: 1'b0, buffer: 8'd0, stamp: clock_q} : head;
	assign shift      = (state_q == S_SCAN);
	assign load_d     = '{valid: 1'b1, buffer: req_q.buffer, stamp: clock_q};
	assign prog_ok    = 32'(request.program_req) < PROGRAMS;
	assign bad_bind   = (request.program_req == 4'd0) || !prog_ok;
	assign req_buf_ok = 32'(request.buffer) < BUFFERS;
	assign prog_idx   = PW'(req_q.program_req);
	assign mask       = {{(PROGRAMS-1){1'b0}}, 1'b1} << prog_idx;
	assign used       = ev_bufok_s1 && ram_rd[prog_idx];
	assign ram_ra     = (state_q == S_SCAN) ? AW'(head.buffer) : AW'(req_q.buffer);

	genvar gi;
	generate
		for (gi = 0; gi < SLOTS; gi++) begin : g_cell
			slot_t d_in;
			if (gi == SLOTS - 1) begin : g_last
				assign d_in = tail_d;
			end else begin : g_mid
				assign d_in = cell_q[gi+1];
			end
			blsa_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.clr    (clr_all),
				.load   (load_en && (sel_idx == IW'(gi))),
				.d      (d_in),
				.load_d (load_d),
				.q      (cell_q[gi])
			);
		end
	endgenerate

	blsa_ram #(.WIDTH(PROGRAMS), .DEPTH(BUFFERS)) u_users (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_wa),
		.wdata (ram_wd),
		.raddr (ram_ra),
		.rdata (ram_rd)
	);

	always_comb begin
		state_d = state_q;
		emit    = 1'b0;
		emit_r  = '{unit: 6'd0, status: STAT_OK};
		ram_we  = 1'b0;
		ram_wa  = clr_q;
		ram_wd  = '0;
		clr_all = 1'b0;
		load_en = 1'b0;
		sel_idx = hit_idx_q;
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				if (clr_q == AW'(BUFFERS - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					case (request.kind)
						KIND_BIND: begin
							if (bad_bind) begin
								emit = 1'b1;
								emit_r.status = STAT_BAD_PROGRAM;
							end else if (!req_buf_ok) begin
								emit = 1'b1;
								emit_r.status = STAT_NO_SLOT;
							end else begin
								state_d = S_SCAN;
							end
						end
						KIND_ADD, KIND_REMOVE: begin
							if (!prog_ok) begin
								emit = 1'b1;
								emit_r.status = STAT_BAD_PROGRAM;
							end else if (!req_buf_ok) begin
								emit = 1'b1;
							end else begin
								state_d = S_UREAD;
							end
						end
						KIND_RELEASE: begin
							if (!req_buf_ok) emit = 1'b1;
							else state_d = S_SCAN;
						end
						KIND_UNBIND: begin
							clr_all = 1'b1;
							emit    = 1'b1;
						end
						default: emit = 1'b1;
					endcase
				end
			end
			S_SCAN: begin
				if (idx_q == IW'(SLOTS - 1)) state_d = S_TAIL;
			end
			S_TAIL: begin
				if (req_q.kind == KIND_RELEASE) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_APPLY;
				end
			end
			S_APPLY: begin
				state_d = S_IDLE;
				emit    = 1'b1;
				if (hit_q || free_q || best_q) begin
					// held slot first, then lowest free, then oldest eligible
					sel_idx = hit_q ? hit_idx_q : (free_q ? free_idx_q : best_idx_q);
					load_en = 1'b1;
					emit_r.unit = 6'(sel_idx);
				end else begin
					emit_r.status = STAT_NO_SLOT;
				end
			end
			S_UREAD: state_d = S_UWRITE;
			S_UWRITE: begin
				state_d = S_IDLE;
				emit    = 1'b1;
				ram_wa  = AW'(req_q.buffer);
				if (req_q.kind == KIND_ADD) begin
					if ((ram_rd & mask) != '0) emit_r.status = STAT_USER_PRESENT;
					else ram_we = 1'b1;
					ram_wd = ram_rd | mask;
				end else begin
					if ((ram_rd & mask) == '0) emit_r.status = STAT_USER_ABSENT;
					else ram_we = 1'b1;
					ram_wd = ram_rd & ~mask;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			clock_q <= '0;
			units_q <= UNITS_RESET;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			best_q  <= 1'b0;
			ev_s1   <= 1'b0;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			ev_s1   <= (state_q == S_SCAN);
			if (cfg_we) units_q <= cfg_wdata;
			if (state_q == S_CLEAR) clr_q <= clr_q + AW'(1);
			if (state_q == S_IDLE && start) begin
				idx_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
				best_q <= 1'b0;
			end
			if (state_q == S_SCAN) begin
				idx_q <= idx_q + IW'(1);
				if (head_match) hit_q <= 1'b1;
				if (!head.valid && (7'(idx_q) < units_q) && !free_q) free_q <= 1'b1;
				if (rel_free) clock_q <= clock_q + 32'd1;
			end
			// candidate check in the cycle after the ring head is seen, once the user bitmap is read
			if (ev_s1 && (7'(ev_idx_s1) < units_q) && !used &&
			    (!best_q || ev_stamp_s1 < oldest_q)) begin
				best_q <= 1'b1;
			end
			if (load_en) clock_q <= clock_q + 32'd1;
			if (clr_all) clock_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) req_q <= request;
		result_q <= emit_r;
		ev_idx_s1   <= idx_q;
		ev_stamp_s1 <= head.stamp;
		ev_bufok_s1 <= 32'(head.buffer) < BUFFERS;
		if (state_q == S_SCAN) begin
			if (head_match) hit_idx_q <= idx_q;
			if (!head.valid && (7'(idx_q) < units_q) && !free_q) free_idx_q <= idx_q;
		end
		if (ev_s1 && (7'(ev_idx_s1) < units_q) && !used &&
		    (!best_q || ev_stamp_s1 < oldest_q)) begin
			best_idx_q <= ev_idx_s1;
			oldest_q   <= ev_stamp_s1;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;
endmodule

/* rtl/blsa_checker.sv */
`timescale 1ns / 1ps
module blsa_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input blsa_pkg::in_t  request,
	input logic           done,
	input blsa_pkg::out_t result
);
	import blsa_pkg::*;

	a_unit_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != STAT_OK |-> result.unit == 6'd0)
		else $error("unit set on a failed transfer");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || $past(start))
		else $error("result without request");

	a_unbind_fast: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && request.kind == KIND_UNBIND |=> done && result.status == STAT_OK)
		else $error("unbind all not answered at once");

	a_bad_program: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && request.kind == KIND_BIND && request.program_req == 4'd0
		|=> done && result.status == STAT_BAD_PROGRAM)
		else $error("bind with program zero not rejected");
endmodule

bind binding_slot_lru_allocator_core blsa_checker u_blsa_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
	import blsa_pkg::*;

	localparam int NSLOT = SLOTS_DEF;
	localparam int NBUF  = BUFFERS_DEF;
	localparam int NPROG = PROGRAMS_DEF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_t request = '0;
	logic done;
	out_t result;
	logic cfg_we = 1'b0;
	logic [6:0] cfg_wdata = '0;

	binding_slot_lru_allocator_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Shadow copy of the allocator state
	bit [7:0]  shadow_buf[NSLOT];
	bit        shadow_valid[NSLOT];
	bit [31:0] shadow_stamp[NSLOT];
	bit        buf_bound[NBUF];
	bit [5:0]  buf_unit[NBUF];
	bit [15:0] buf_users[NBUF];
	bit [31:0] bind_tick;
	bit [6:0]  usable_units;

	out_t pending_results[$];
	int   fail_count = 0;
	bit   no_idle = 0;

	function automatic void drop_slot(int s, bit [31:0] stamp);
		if (shadow_valid[s]) buf_bound[shadow_buf[s]] = 0;
		shadow_valid[s] = 0;
		shadow_buf[s] = '0;
		shadow_stamp[s] = stamp;
	endfunction

	function automatic int choose_victim(bit [3:0] prog);
		int n;
		int best;
		bit [31:0] oldest;
		n = (usable_units > NSLOT) ? NSLOT : usable_units;
		best = -1;
		oldest = '0;
		for (int i = 0; i < n; i++)
			if (!shadow_valid[i]) return i;
		for (int i = 0; i < n; i++) begin
			if (!buf_users[shadow_buf[i]][prog] && (best < 0 || shadow_stamp[i] < oldest)) begin
				best = i;
				oldest = shadow_stamp[i];
			end
		end
		return best;
	endfunction

	function automatic out_t allocate_predict(in_t r);
		out_t o;
		int s;
		o.unit = '0;
		o.status = STAT_OK;
		case (r.kind)
			KIND_BIND: begin
				if (r.program_req == 0) o.status = STAT_BAD_PROGRAM;
				else begin
					s = buf_bound[r.buffer] ? int'(buf_unit[r.buffer]) : choose_victim(r.program_req);
					if (s < 0) o.status = STAT_NO_SLOT;
					else begin
						if (!(shadow_valid[s] && shadow_buf[s] == r.buffer)) drop_slot(s, '0);
						shadow_valid[s] = 1;
						shadow_buf[s] = r.buffer;
						shadow_stamp[s] = bind_tick;
						bind_tick++;
						buf_bound[r.buffer] = 1;
						buf_unit[r.buffer] = s[5:0];
						o.unit = s[5:0];
					end
				end
			end
			KIND_ADD: begin
				if (buf_users[r.buffer][r.program_req]) o.status = STAT_USER_PRESENT;
				else buf_users[r.buffer][r.program_req] = 1;
			end
			KIND_REMOVE: begin
				if (!buf_users[r.buffer][r.program_req]) o.status = STAT_USER_ABSENT;
				else buf_users[r.buffer][r.program_req] = 0;
			end
			KIND_RELEASE: begin
				for (int i = 0; i < NSLOT; i++) begin
					if (shadow_valid[i] && shadow_buf[i] == r.buffer) begin
						drop_slot(i, bind_tick);
						bind_tick++;
					end
				end
			end
			KIND_UNBIND: begin
				for (int i = 0; i < NSLOT; i++) drop_slot(i, '0);
				bind_tick = '0;
			end
			default: ;
		endcase
		return o;
	endfunction

	task automatic report(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		fail_count++;
	endtask

	always @(posedge clk) begin
		out_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) report("result with nothing pending");
			else begin
				want = pending_results.pop_front();
				if (result.unit !== want.unit)
					report($sformatf("unit %0d, want %0d", result.unit, want.unit));
				if (result.status !== want.status)
					report($sformatf("status %0d, want %0d", result.status, want.status));
			end
		end
	end

	// Call right after a rising edge; leaves start high unless an idle gap follows
	task automatic send(bit [2:0] k, bit [7:0] b, bit [3:0] p);
		in_t r;
		r.kind = k;
		r.buffer = b;
		r.program_req = p;
		start <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
		pending_results = {pending_results, allocate_predict(r)};
		if (!no_idle && $urandom_range(99) < 27) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_units(bit [6:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		usable_units = v;
		@(posedge clk);
	endtask

	task automatic test_directed();
		send(KIND_BIND, 8'd0, 4'd0);
		send(KIND_BIND, 8'd0, 4'd1);
		send(KIND_BIND, 8'd0, 4'd1);
		send(KIND_BIND, 8'd255, 4'd15);
		send(KIND_ADD, 8'd0, 4'd0);
		send(KIND_ADD, 8'd0, 4'd0);
		send(KIND_ADD, 8'd255, 4'd15);
		send(KIND_REMOVE, 8'd0, 4'd3);
		send(KIND_REMOVE, 8'd0, 4'd0);
		send(KIND_RELEASE, 8'd0, 4'd0);
		send(KIND_RELEASE, 8'd77, 4'd0);
		send(KIND_BIND, 8'd170, 4'd10);
		send(KIND_UNBIND, 8'd0, 4'd0);
		send(3'd5, 8'd85, 4'd5);
		send(3'd6, 8'd0, 4'd0);
		send(3'd7, 8'd255, 4'd15);
	endtask

	// Fill slots with buffers the requester uses, then hit the exclusion and limits
	task automatic test_units_limits();
		set_units(7'd2);
		send(KIND_ADD, 8'd1, 4'd2);
		send(KIND_ADD, 8'd2, 4'd2);
		send(KIND_BIND, 8'd1, 4'd2);
		send(KIND_BIND, 8'd2, 4'd2);
		send(KIND_BIND, 8'd3, 4'd2);
		send(KIND_BIND, 8'd3, 4'd4);
		send(KIND_BIND, 8'd4, 4'd4);
		set_units(7'd64);
		for (int i = 0; i < 6; i++) send(KIND_BIND, 8'(20 + i), 4'd1);
		set_units(7'd1);
		send(KIND_BIND, 8'd25, 4'd1);
		send(KIND_BIND, 8'd40, 4'd1);
		set_units(7'd0);
		send(KIND_BIND, 8'd24, 4'd1);
		send(KIND_BIND, 8'd41, 4'd1);
		set_units(7'd127);
		send(KIND_BIND, 8'd42, 4'd1);
		send(KIND_UNBIND, 8'd0, 4'd0);
	endtask

	task automatic random_item(int pool);
		int sel;
		bit [2:0] k;
		bit [7:0] b;
		sel = $urandom_range(99);
		if (sel < 50) k = KIND_BIND;
		else if (sel < 68) k = KIND_ADD;
		else if (sel < 78) k = KIND_REMOVE;
		else if (sel < 90) k = KIND_RELEASE;
		else if (sel < 93) k = KIND_UNBIND;
		else k = 3'($urandom_range(5, 7));
		b = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(pool - 1));
		send(k, b, 4'($urandom_range(15)));
	endtask

	task automatic test_random();
		bit [6:0] plan[8] = '{7'd3, 7'd64, 7'd1, 7'd8, 7'd0, 7'd127, 7'd5, 7'd64};
		for (int ph = 0; ph < 8; ph++) begin
			set_units(plan[ph]);
			no_idle = (ph == 3);
			for (int i = 0; i < 70; i++)
				random_item((plan[ph] > 40) ? 96 : 3 * plan[ph] + 4);
		end
		no_idle = 0;
		set_units(7'($urandom_range(1, 64)));
		for (int i = 0; i < 40; i++) random_item(32);
	endtask

	initial begin
		usable_units = UNITS_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_units_limits();
		test_random();
		drain();
		repeat (80) @(posedge clk);
		if (fail_count == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end
endmodule
